[hdl/i2cm_pkg.sv]
// Shared types, codes and the segment plans of the I2C register-access master.
package i2cm_pkg;

	// Request codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_WR_REJECT = 2'd1;
	localparam logic [1:0] ST_RD_REJECT = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DEV_ADDR  = 1'b0;
	localparam logic CFG_ACK_LIMIT = 1'b1;

	// Reset values of configuration registers
	localparam logic [7:0] DEV_ADDR_RST  = 8'd152;
	localparam logic [7:0] ACK_LIMIT_RST = 8'd255;

	// Accepted register address windows
	localparam logic [7:0] REG_LO    = 8'h10;
	localparam logic [7:0] WR_REG_HI = 8'h15;
	localparam logic [7:0] RD_REG_HI = 8'h17;

	// Plan lengths in segments
	localparam logic [4:0] WR_PLAN_LEN = 5'd11;
	localparam logic [4:0] RD_PLAN_LEN = 5'd13;

	// Step number of the first read byte (loads the high byte)
	localparam logic [4:0] STEP_RD_MSB = 5'd9;

	typedef enum logic [3:0] {
		SEG_START,
		SEG_WB_DEVW,
		SEG_WB_DEVR,
		SEG_WB_REG,
		SEG_WB_MSB,
		SEG_WB_LSB,
		SEG_WAIT,
		SEG_RB,
		SEG_ACK,
		SEG_NACK,
		SEG_STOP,
		SEG_GAP
	} seg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  reg_address;
		logic [15:0] write_data;
		logic        sda_in;
	} req_t;

	typedef struct packed {
		logic        scl_out;
		logic        sda_out;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic [7:0] dev_addr;
		logic [7:0] ack_limit;
	} cfg_t;

	// Segment of a plan at a zero-based position
	function automatic seg_t plan_seg(input logic is_read, input logic [3:0] idx);
		seg_t s;
		s = SEG_GAP;
		if (is_read) begin
			case (idx)
				4'd0:  s = SEG_START;
				4'd1:  s = SEG_WB_DEVW;
				4'd2:  s = SEG_WAIT;
				4'd3:  s = SEG_WB_REG;
				4'd4:  s = SEG_WAIT;
				4'd5:  s = SEG_START;
				4'd6:  s = SEG_WB_DEVR;
				4'd7:  s = SEG_WAIT;
				4'd8:  s = SEG_RB;
				4'd9:  s = SEG_ACK;
				4'd10: s = SEG_RB;
				4'd11: s = SEG_NACK;
				default: s = SEG_STOP;
			endcase
		end else begin
			case (idx)
				4'd0:  s = SEG_START;
				4'd1:  s = SEG_WB_DEVW;
				4'd2:  s = SEG_WAIT;
				4'd3:  s = SEG_WB_REG;
				4'd4:  s = SEG_WAIT;
				4'd5:  s = SEG_WB_MSB;
				4'd6:  s = SEG_WAIT;
				4'd7:  s = SEG_WB_LSB;
				4'd8:  s = SEG_WAIT;
				4'd9:  s = SEG_STOP;
				default: s = SEG_GAP;
			endcase
		end
		return s;
	endfunction

endpackage

[hdl/i2cm_core.sv]
// Bus sequencer state and the single-tick step logic of the I2C master.
module i2cm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_en,
	input  i2cm_pkg::req_t  req_s1,
	input  i2cm_pkg::cfg_t  cfg,
	output i2cm_pkg::rsp_t  rsp_d
);

	logic [4:0]  step_q;
	logic [1:0]  phase_q;
	logic [3:0]  bitc_q;
	logic [7:0]  shift_q;
	logic [7:0]  waitc_q;
	logic [15:0] cap_q;
	logic [24:0] held_q;
	logic        scl_q;
	logic        sda_q;

	logic [4:0]  n_step;
	logic [1:0]  n_phase;
	logic [3:0]  n_bitc;
	logic [7:0]  n_shift;
	logic [7:0]  n_waitc;
	logic [15:0] n_cap;
	logic [24:0] n_held;
	logic        n_scl;
	logic        n_sda;

	// One tick: request decode, one segment phase, then plan advance
	always_comb begin
		logic            run;
		logic            seg_end;
		logic            late;
		logic [4:0]      count;
		logic [4:0]      idx;
		logic [7:0]      tx_byte;
		i2cm_pkg::seg_t  kind;

		n_step  = step_q;
		n_phase = phase_q;
		n_bitc  = bitc_q;
		n_shift = shift_q;
		n_waitc = waitc_q;
		n_cap   = cap_q;
		n_held  = held_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		run     = 1'b0;
		seg_end = 1'b0;
		late    = 1'b0;
		count   = i2cm_pkg::WR_PLAN_LEN;
		idx     = '0;
		tx_byte = '0;
		kind    = i2cm_pkg::SEG_GAP;
		rsp_d   = '0;

		// Idle: check and latch a new request
		if (step_q == 5'd0) begin
			case (req_s1.operation)
				i2cm_pkg::OP_WRITE: begin
					if (req_s1.reg_address < i2cm_pkg::REG_LO ||
					    req_s1.reg_address > i2cm_pkg::WR_REG_HI) begin
						rsp_d.done_res = 1'b1;
						rsp_d.status   = i2cm_pkg::ST_WR_REJECT;
					end else begin
						n_held = {1'b0, req_s1.reg_address, req_s1.write_data};
						run    = 1'b1;
					end
				end
				i2cm_pkg::OP_READ: begin
					if (req_s1.reg_address < i2cm_pkg::REG_LO ||
					    req_s1.reg_address > i2cm_pkg::RD_REG_HI) begin
						rsp_d.done_res = 1'b1;
						rsp_d.status   = i2cm_pkg::ST_RD_REJECT;
					end else begin
						n_held = {1'b1, req_s1.reg_address, 16'h0000};
						run    = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (run) begin
				n_step  = 5'd1;
				n_phase = 2'd0;
				n_bitc  = 4'd0;
			end
		end else begin
			run = 1'b1;
		end

		if (run) begin
			count = n_held[24] ? i2cm_pkg::RD_PLAN_LEN : i2cm_pkg::WR_PLAN_LEN;
			idx   = n_step - 5'd1;
			if (idx >= count) begin
				idx = count - 5'd1;
			end
			kind = i2cm_pkg::plan_seg(n_held[24], idx[3:0]);
			rsp_d.busy_res = 1'b1;

			// Byte to send for write segments
			case (kind)
				i2cm_pkg::SEG_WB_DEVW: tx_byte = cfg.dev_addr & 8'hFE;
				i2cm_pkg::SEG_WB_DEVR: tx_byte = cfg.dev_addr | 8'h01;
				i2cm_pkg::SEG_WB_REG:  tx_byte = n_held[23:16];
				i2cm_pkg::SEG_WB_MSB:  tx_byte = n_held[15:8] & 8'h7F;
				default:               tx_byte = n_held[7:0];
			endcase

			case (kind)
				i2cm_pkg::SEG_START: begin
					if (n_phase == 2'd0) begin
						n_sda = 1'b1;
					end else if (n_phase == 2'd1) begin
						n_scl = 1'b1;
					end else begin
						n_sda   = 1'b0;
						seg_end = 1'b1;
					end
					if (!seg_end) n_phase = n_phase + 2'd1;
				end
				i2cm_pkg::SEG_STOP: begin
					if (n_phase == 2'd0) begin
						n_sda = 1'b0;
					end else if (n_phase == 2'd1) begin
						n_scl = 1'b1;
					end else begin
						n_sda   = 1'b1;
						seg_end = 1'b1;
					end
					if (!seg_end) n_phase = n_phase + 2'd1;
				end
				i2cm_pkg::SEG_GAP: begin
					seg_end = 1'b1;
				end
				i2cm_pkg::SEG_WAIT: begin
					// Clock high, then spin while the target holds the line high
					if (n_phase == 2'd0) begin
						n_scl   = 1'b1;
						n_waitc = 8'd0;
						n_phase = 2'd1;
					end else if (req_s1.sda_in && n_waitc < cfg.ack_limit) begin
						n_waitc = n_waitc + 8'd1;
					end else begin
						n_scl   = 1'b0;
						seg_end = 1'b1;
					end
				end
				i2cm_pkg::SEG_ACK, i2cm_pkg::SEG_NACK: begin
					// Clock drops after the high tick is shown
					if (n_phase == 2'd0) begin
						n_scl   = 1'b0;
						n_sda   = (kind == i2cm_pkg::SEG_NACK);
						n_phase = 2'd1;
					end else begin
						n_scl   = 1'b1;
						late    = 1'b1;
						seg_end = 1'b1;
					end
				end
				i2cm_pkg::SEG_RB: begin
					case (n_phase)
						2'd0: begin
							n_scl   = 1'b0;
							n_shift = 8'd0;
							n_phase = 2'd1;
						end
						2'd1: begin
							n_sda   = 1'b1;
							n_scl   = 1'b1;
							n_shift = {n_shift[6:0], req_s1.sda_in};
							n_phase = 2'd2;
						end
						2'd2: begin
							n_scl   = 1'b0;
							n_bitc  = n_bitc + 4'd1;
							n_phase = (n_bitc >= 4'd8) ? 2'd3 : 2'd1;
						end
						default: begin
							if (n_step == i2cm_pkg::STEP_RD_MSB) begin
								n_cap = {n_shift, 8'h00};
							end else begin
								n_cap = {n_cap[15:8], n_shift};
							end
							seg_end = 1'b1;
						end
					endcase
				end
				default: begin
					// Byte write, MSB first, then release for the ack
					if (n_bitc < 4'd8) begin
						if (n_phase == 2'd0) begin
							if (n_bitc == 4'd0) n_shift = tx_byte;
							n_scl   = 1'b0;
							n_phase = 2'd1;
						end else if (n_phase == 2'd1) begin
							n_sda   = n_shift[7];
							n_shift = {n_shift[6:0], 1'b0};
							n_phase = 2'd2;
						end else begin
							n_scl   = 1'b1;
							n_bitc  = n_bitc + 4'd1;
							n_phase = 2'd0;
						end
					end else if (n_phase == 2'd0) begin
						n_scl   = 1'b0;
						n_phase = 2'd1;
					end else begin
						n_sda   = 1'b1;
						seg_end = 1'b1;
					end
				end
			endcase

			// Plan advance
			if (seg_end) begin
				n_phase = 2'd0;
				n_bitc  = 4'd0;
				n_step  = n_step + 5'd1;
				if (n_step > count) begin
					n_step         = 5'd0;
					rsp_d.done_res = 1'b1;
				end
			end
		end

		rsp_d.scl_out   = n_scl;
		rsp_d.sda_out   = n_sda;
		rsp_d.read_data = n_cap;
		if (late) n_scl = 1'b0;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			phase_q <= '0;
			bitc_q  <= '0;
			shift_q <= '0;
			waitc_q <= '0;
			cap_q   <= '0;
			held_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (tick_en) begin
			step_q  <= n_step;
			phase_q <= n_phase;
			bitc_q  <= n_bitc;
			shift_q <= n_shift;
			waitc_q <= n_waitc;
			cap_q   <= n_cap;
			held_q  <= n_held;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
		end
	end

endmodule

[hdl/i2c_master_register_access_top.sv]
// Top level of the I2C register-access master: input stage, sequencer, result register.
// A tick transferred on req passes the input stage, then the result register, before it is on rsp.
// Throughput: one tick per cycle while rsp_stall is low; the sequencer takes one bus phase per tick in one pass.
// req_stall rises only while the input stage holds a tick and the result register is stalled.
// Reset (arst_n low): sequencer idle, both lines released high, captured word cleared,
// device address 152 and ack wait limit 255; input stage and result register empty.
module i2c_master_register_access_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2cm_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2cm_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [7:0]      cfg_data
);

	i2cm_pkg::cfg_t  cfg_q;
	i2cm_pkg::req_t  req_s1;
	logic            valid_s1;
	i2cm_pkg::rsp_t  rsp_d;
	i2cm_pkg::rsp_t  rsp_s2;
	logic            valid_s2;
	logic            advance;
	logic            tick_en;

	// Result register takes a new tick when empty or being drained
	assign advance   = !valid_s2 || !rsp_stall;
	assign tick_en   = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr  <= i2cm_pkg::DEV_ADDR_RST;
			cfg_q.ack_limit <= i2cm_pkg::ACK_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cm_pkg::CFG_DEV_ADDR:  cfg_q.dev_addr  <= cfg_data;
				i2cm_pkg::CFG_ACK_LIMIT: cfg_q.ack_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	i2cm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (tick_en),
		.req_s1  (req_s1),
		.cfg     (cfg_q),
		.rsp_d   (rsp_d)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (tick_en) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A rejected request never starts a transaction
	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.status != i2cm_pkg::ST_OK |-> !rsp_s2.busy_res && rsp_s2.done_res)
		else $error("rejected request reported as busy or not done");

	// A held tick with a free result register moves on in the next cycle
	a_tick_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("tick not transferred to result register");

	// The input only stalls behind a held tick
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && rsp_stall)
		else $error("input stalled without a blocked result");

endmodule

[tb/sv/tb_i2c_master_register_access_top.sv]
// Self-checking testbench for the I2C register-access master: bit-level predictor and scoreboard.
module tb_i2c_master_register_access_top;
	import i2cm_pkg::*;

	// Operation code with no meaning of its own; the block treats it as a plain tick
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [4:0] STEP_IDLE = 5'd0;

	// Pin levels and flags that follow from the request alone while idle after reset
	localparam rsp_t RSP_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b0, status: ST_OK, read_data: 16'h0000};
	localparam rsp_t RSP_WR_REJ = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b1, status: ST_WR_REJECT, read_data: 16'h0000};
	localparam rsp_t RSP_RD_REJ = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b1, status: ST_RD_REJECT, read_data: 16'h0000};

	// Segment order of a register write and a register read
	localparam seg_t WR_PLAN [0:10] = '{SEG_START, SEG_WB_DEVW, SEG_WAIT, SEG_WB_REG,
		SEG_WAIT, SEG_WB_MSB, SEG_WAIT, SEG_WB_LSB, SEG_WAIT, SEG_STOP, SEG_GAP};
	localparam seg_t RD_PLAN [0:12] = '{SEG_START, SEG_WB_DEVW, SEG_WAIT, SEG_WB_REG,
		SEG_WAIT, SEG_START, SEG_WB_DEVR, SEG_WAIT, SEG_RB, SEG_ACK, SEG_RB, SEG_NACK,
		SEG_STOP};

	// Device address and ack wait limit per test phase (phase 4 is drawn at random)
	localparam cfg_t BUS_SETUPS [1:5] = '{'{8'h00, 8'd0}, '{8'hFF, 8'd255},
		'{8'h5A, 8'd3}, '{8'h00, 8'd0}, '{8'hA7, 8'd1}};

	typedef enum logic [1:0] {ACK_RANDOM, ACK_LOW, ACK_HIGH} ack_style_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_DEV_ADDR;
	logic [7:0]  cfg_data = 8'h00;

	// Predictor state of the bus sequencer
	logic [4:0]  seq_step = STEP_IDLE;
	logic [1:0]  phase_cnt = 2'd0;
	logic [3:0]  bit_cnt = 4'd0;
	logic [7:0]  shift_reg = 8'd0;
	logic [7:0]  wait_cnt = 8'd0;
	logic [15:0] rd_word = 16'd0;
	logic [24:0] held_req = 25'd0;
	logic        scl_lvl = 1'b1;
	logic        sda_lvl = 1'b1;
	logic [7:0]  dev_addr = DEV_ADDR_RST;
	logic [7:0]  ack_limit = ACK_LIMIT_RST;

	rsp_t        bus_results_due[$];
	rsp_t        rsp_want;
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	logic [9:0]  stall_tick = '0;
	stall_mode_t stall_mode = STALL_NONE;
	dir_row_t    dir_rows[$];

	i2c_master_register_access_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// One bus phase: advances the sequencer and returns the pins and flags of this tick
	function automatic rsp_t next_bus_phase(input req_t r);
		rsp_t       o;
		logic       run;
		logic       late;
		logic       fin;
		logic       rd;
		logic [4:0] plan_len;
		logic [4:0] idx;
		logic [1:0] p;
		seg_t       seg;
		o = '0;
		run = 1'b0;
		late = 1'b0;
		fin = 1'b0;
		if (seq_step == STEP_IDLE) begin
			if (r.operation == OP_WRITE) begin
				if (r.reg_address < REG_LO || r.reg_address > WR_REG_HI) begin
					o.done_res = 1'b1;
					o.status = ST_WR_REJECT;
				end else begin
					held_req = {1'b0, r.reg_address, r.write_data};
					run = 1'b1;
				end
			end else if (r.operation == OP_READ) begin
				if (r.reg_address < REG_LO || r.reg_address > RD_REG_HI) begin
					o.done_res = 1'b1;
					o.status = ST_RD_REJECT;
				end else begin
					held_req = {1'b1, r.reg_address, 16'h0000};
					run = 1'b1;
				end
			end
			if (run) begin
				seq_step = 5'd1;
				phase_cnt = 2'd0;
				bit_cnt = 4'd0;
			end
		end else begin
			run = 1'b1;
		end

		if (run) begin
			rd = held_req[24];
			plan_len = rd ? RD_PLAN_LEN : WR_PLAN_LEN;
			idx = seq_step - 5'd1;
			if (idx >= plan_len)
				idx = plan_len - 5'd1;
			seg = rd ? RD_PLAN[idx] : WR_PLAN[idx];
			o.busy_res = 1'b1;
			p = phase_cnt;
			case (seg)
				SEG_START: begin
					if (p == 2'd0) sda_lvl = 1'b1;
					else if (p == 2'd1) scl_lvl = 1'b1;
					else begin
						sda_lvl = 1'b0;
						fin = 1'b1;
					end
					if (!fin) phase_cnt = p + 2'd1;
				end
				SEG_STOP: begin
					if (p == 2'd0) sda_lvl = 1'b0;
					else if (p == 2'd1) scl_lvl = 1'b1;
					else begin
						sda_lvl = 1'b1;
						fin = 1'b1;
					end
					if (!fin) phase_cnt = p + 2'd1;
				end
				SEG_GAP: fin = 1'b1;
				SEG_WAIT: begin
					// clock high, then spin while the target leaves the line high
					if (p == 2'd0) begin
						scl_lvl = 1'b1;
						wait_cnt = 8'd0;
						phase_cnt = 2'd1;
					end else if (r.sda_in && wait_cnt < ack_limit) begin
						wait_cnt = wait_cnt + 8'd1;
					end else begin
						scl_lvl = 1'b0;
						fin = 1'b1;
					end
				end
				SEG_ACK, SEG_NACK: begin
					// clock drops after the output of the high tick
					if (p == 2'd0) begin
						scl_lvl = 1'b0;
						sda_lvl = (seg == SEG_NACK);
						phase_cnt = 2'd1;
					end else begin
						scl_lvl = 1'b1;
						late = 1'b1;
						fin = 1'b1;
					end
				end
				SEG_RB: begin
					if (p == 2'd0) begin
						scl_lvl = 1'b0;
						shift_reg = 8'd0;
						phase_cnt = 2'd1;
					end else if (p == 2'd1) begin
						sda_lvl = 1'b1;
						scl_lvl = 1'b1;
						shift_reg = {shift_reg[6:0], r.sda_in};
						phase_cnt = 2'd2;
					end else if (p == 2'd2) begin
						scl_lvl = 1'b0;
						bit_cnt = bit_cnt + 4'd1;
						phase_cnt = (bit_cnt >= 4'd8) ? 2'd3 : 2'd1;
					end else begin
						if (seq_step == STEP_RD_MSB) rd_word = {shift_reg, 8'h00};
						else rd_word[7:0] = shift_reg;
						fin = 1'b1;
					end
				end
				default: begin
					// byte out, MSB first: clock low, data, clock high per bit
					if (bit_cnt < 4'd8) begin
						if (p == 2'd0) begin
							if (bit_cnt == 4'd0) begin
								case (seg)
									SEG_WB_DEVW: shift_reg = dev_addr & 8'hFE;
									SEG_WB_DEVR: shift_reg = dev_addr | 8'h01;
									SEG_WB_REG:  shift_reg = held_req[23:16];
									SEG_WB_MSB:  shift_reg = {1'b0, held_req[14:8]};
									default:     shift_reg = held_req[7:0];
								endcase
							end
							scl_lvl = 1'b0;
							phase_cnt = 2'd1;
						end else if (p == 2'd1) begin
							sda_lvl = shift_reg[7];
							shift_reg = {shift_reg[6:0], 1'b0};
							phase_cnt = 2'd2;
						end else begin
							scl_lvl = 1'b1;
							bit_cnt = bit_cnt + 4'd1;
							phase_cnt = 2'd0;
						end
					end else if (p == 2'd0) begin
						scl_lvl = 1'b0;
						phase_cnt = 2'd1;
					end else begin
						sda_lvl = 1'b1;
						fin = 1'b1;
					end
				end
			endcase
			if (fin) begin
				phase_cnt = 2'd0;
				bit_cnt = 4'd0;
				seq_step = seq_step + 5'd1;
				if (seq_step > plan_len) begin
					seq_step = STEP_IDLE;
					o.done_res = 1'b1;
				end
			end
		end

		o.scl_out = scl_lvl;
		o.sda_out = sda_lvl;
		o.read_data = rd_word;
		if (late)
			scl_lvl = 1'b0;
		return o;
	endfunction

	function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] addr,
			input logic [15:0] data, input logic sda, input bit typed, input rsp_t want);
		dir_row_t row;
		row.item = '{operation: op, reg_address: addr, write_data: data, sda_in: sda};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic logic ack_level(input ack_style_t style);
		logic lvl;
		case (style)
			ACK_LOW:  lvl = ($urandom_range(0, 7) == 0);
			ACK_HIGH: lvl = 1'b1;
			default:  lvl = $urandom_range(0, 1);
		endcase
		return lvl;
	endfunction

	function automatic void cmp_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Send one tick in bursts with random gaps; the expectation is taken on transfer
	task automatic send_item(input req_t item, input bit typed, input rsp_t typed_rsp);
		int   gap;
		rsp_t due;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		due = next_bus_phase(item);
		bus_results_due.push_back(typed ? typed_rsp : due);
		burst_left--;
		items_sent++;
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		burst_left = 0;
		while (bus_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_DEV_ADDR) dev_addr = val;
		else ack_limit = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Plain ticks (with the odd ignored request) until the sequencer is back to idle
	task automatic tick_until_idle(input ack_style_t style);
		req_t r;
		while (seq_step != STEP_IDLE) begin
			r.operation = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
			r.reg_address = 8'($urandom);
			r.write_data = 16'($urandom);
			r.sda_in = ack_level(style);
			send_item(r, 1'b0, RSP_IDLE);
		end
	endtask

	// One request, mostly well formed, then run it to completion
	task automatic run_transaction();
		req_t       r;
		ack_style_t style;
		int         pick;
		if ($urandom_range(0, 4) == 0)
			drain_results();
		pick = $urandom_range(0, 19);
		case ($urandom_range(0, 5))
			0: r.write_data = 16'hFFFF;
			1: r.write_data = 16'h0000;
			2: r.write_data = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: r.write_data = 16'($urandom);
		endcase
		r.sda_in = $urandom_range(0, 1);
		if (pick < 9) begin
			r.operation = OP_WRITE;
			r.reg_address = REG_LO + 8'($urandom_range(0, 5));
		end else if (pick < 18) begin
			r.operation = OP_READ;
			r.reg_address = REG_LO + 8'($urandom_range(0, 7));
		end else begin
			r.operation = 2'($urandom_range(0, 3));
			r.reg_address = 8'($urandom);
		end
		if ($urandom_range(0, 5) == 0)
			r.reg_address = 8'($urandom);
		send_item(r, 1'b0, RSP_IDLE);
		style = ack_style_t'($urandom_range(0, 1));
		if (ack_limit <= 8'd20 && $urandom_range(0, 3) == 0)
			style = ACK_HIGH;
		tick_until_idle(style);
	endtask

	// Result side: stall pattern whose mode is redrawn whenever the low byte of stall_tick is zero
	always @(negedge clk) begin
		stall_tick <= stall_tick + 10'd1;
		if (stall_tick[7:0] == 8'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
			default:     rsp_stall <= (stall_tick[2:0] >= 3'd5);
		endcase
	end

	// Scoreboard: each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (bus_results_due.size() == 0) begin
				$display("%0t: result with none expected, got %p", $time, rsp);
				mismatches++;
			end else begin
				rsp_want = bus_results_due.pop_front();
				cmp_field("scl_out", 16'(rsp_want.scl_out), 16'(rsp.scl_out));
				cmp_field("sda_out", 16'(rsp_want.sda_out), 16'(rsp.sda_out));
				cmp_field("busy_res", 16'(rsp_want.busy_res), 16'(rsp.busy_res));
				cmp_field("done_res", 16'(rsp_want.done_res), 16'(rsp.done_res));
				cmp_field("status", 16'(rsp_want.status), 16'(rsp.status));
				cmp_field("read_data", rsp_want.read_data, rsp.read_data);
			end
		end
	end

	initial begin
		#3000000;
		$display("tb_i2c_master_register_access_top: FAIL");
		$finish;
	end

	initial begin
		cfg_t setup;
		int   phase_base;

		// Directed ticks: idle levels, op three, rejects at both window edges, busy requests
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b1, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_WRITE, 8'h0F, 16'hFFFF, 1'b1, 1'b1, RSP_WR_REJ));
		dir_rows.push_back(mk_row(OP_WRITE, 8'h16, 16'h0000, 1'b0, 1'b1, RSP_WR_REJ));
		dir_rows.push_back(mk_row(OP_WRITE, 8'h00, 16'h8000, 1'b0, 1'b1, RSP_WR_REJ));
		dir_rows.push_back(mk_row(OP_WRITE, 8'hFF, 16'h7FFF, 1'b1, 1'b1, RSP_WR_REJ));
		dir_rows.push_back(mk_row(OP_READ, 8'h0F, 16'h0000, 1'b0, 1'b1, RSP_RD_REJ));
		dir_rows.push_back(mk_row(OP_READ, 8'h18, 16'hFFFF, 1'b1, 1'b1, RSP_RD_REJ));
		dir_rows.push_back(mk_row(OP_READ, 8'h00, 16'h0000, 1'b1, 1'b1, RSP_RD_REJ));
		dir_rows.push_back(mk_row(OP_READ, 8'hFF, 16'hFFFF, 1'b0, 1'b1, RSP_RD_REJ));
		dir_rows.push_back(mk_row(OP_TICK, 8'hFF, 16'hFFFF, 1'b1, 1'b1, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_WRITE, 8'h15, 16'hFFFF, 1'b0, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_READ, 8'h10, 16'h0000, 1'b1, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_WRITE, 8'h0F, 16'h1234, 1'b0, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_UNUSED, 8'h17, 16'h0000, 1'b1, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 16'h0000, 1'b1, 1'b0, RSP_IDLE));
		dir_rows.push_back(mk_row(OP_READ, 8'h17, 16'hFFFF, 1'b0, 1'b0, RSP_IDLE));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		tick_until_idle(ACK_LOW);

		// Random transactions under several bus setups; reset values come first
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain_results();
				setup = BUS_SETUPS[ph];
				if (ph == 4) begin
					setup.dev_addr = 8'($urandom);
					setup.ack_limit = 8'($urandom_range(0, 20));
				end
				write_reg(CFG_DEV_ADDR, setup.dev_addr);
				write_reg(CFG_ACK_LIMIT, setup.ack_limit);
			end
			phase_base = items_sent;
			while (items_sent - phase_base < 150)
				run_transaction();
		end

		drain_results();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("tb_i2c_master_register_access_top: PASS");
		else
			$display("tb_i2c_master_register_access_top: FAIL");
		$finish;
	end

endmodule

[i2c_master_register_access_top.f]
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2c_master_register_access_top.sv
tb/sv/tb_i2c_master_register_access_top.sv
